FILE: src/sfc_pkg.sv
`default_nettype none
package sfc_pkg;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_COLLECT = 2'd1,
    PH_SYNC_A  = 2'd2,
    PH_SYNC_B  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_FRAME  = 2'd0,
    EV_GAINED = 2'd1,
    EV_LOST   = 2'd2
  } event_kind_t;

  typedef struct packed {
    event_kind_t kind;
    logic [15:0] serial;
    logic [31:0] count;
    logic [31:0] delta;
  } event_t;

  localparam int unsigned PaddrWidth = 3;
  localparam logic [0:0] RegSyncValue = 1'b0;
  localparam logic [7:0] SyncValueReset = 8'hff;
  localparam logic [2:0] LastBytePos = 3'd5;

endpackage
`default_nettype wire

FILE: src/sfc_cfg.sv
`default_nettype none
module sfc_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [sfc_pkg::PaddrWidth-1:0]  paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready,
  output logic      [7:0]                      sync_value
);

  logic reg_hit;

  assign reg_hit = (paddr[2:2] == sfc_pkg::RegSyncValue);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= sfc_pkg::SyncValueReset;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      sync_value <= pwdata[7:0];
    end
  end

  always_comb begin
    if (reg_hit) begin
      prdata = {24'd0, sync_value};
    end else begin
      prdata = 32'd0;
    end
  end

endmodule
`default_nettype wire

FILE: src/sfc_core.sv
`default_nettype none
module sfc_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      data_byte,
  input  wire logic [7:0]      sync_value,
  output logic                 ev_valid,
  output sfc_pkg::event_t      ev
);

  sfc_pkg::phase_t phase, phase_next;
  logic [7:0]  previous_byte;
  logic [2:0]  byte_position, byte_position_next;
  logic [39:0] frame_shift, frame_shift_next;
  logic [31:0] previous_count, previous_count_next;
  logic        is_sync;
  logic        frame_end;
  logic [31:0] frame_count;

  assign is_sync     = (data_byte == sync_value);
  assign frame_end   = (byte_position >= sfc_pkg::LastBytePos);
  assign frame_count = {frame_shift[23:0], data_byte};

  always_comb begin
    phase_next = phase;
    case (phase)
      sfc_pkg::PH_HUNT: begin
        if ((previous_byte == sync_value) && is_sync) begin
          phase_next = sfc_pkg::PH_COLLECT;
        end
      end
      sfc_pkg::PH_COLLECT: begin
        if (frame_end) begin
          phase_next = sfc_pkg::PH_SYNC_A;
        end
      end
      sfc_pkg::PH_SYNC_A: begin
        phase_next = is_sync ? sfc_pkg::PH_SYNC_B : sfc_pkg::PH_HUNT;
      end
      sfc_pkg::PH_SYNC_B: begin
        phase_next = is_sync ? sfc_pkg::PH_COLLECT : sfc_pkg::PH_HUNT;
      end
      default: begin
        phase_next = sfc_pkg::PH_HUNT;
      end
    endcase
  end

  always_comb begin
    ev_valid            = 1'b0;
    ev.kind             = sfc_pkg::EV_FRAME;
    ev.serial           = 16'd0;
    ev.count            = 32'd0;
    ev.delta            = 32'd0;
    byte_position_next  = byte_position;
    frame_shift_next    = frame_shift;
    previous_count_next = previous_count;
    case (phase)
      sfc_pkg::PH_HUNT: begin
        if ((previous_byte == sync_value) && is_sync) begin
          ev_valid           = 1'b1;
          ev.kind            = sfc_pkg::EV_GAINED;
          byte_position_next = 3'd0;
        end
      end
      sfc_pkg::PH_COLLECT: begin
        if (frame_end) begin
          ev_valid            = 1'b1;
          ev.kind             = sfc_pkg::EV_FRAME;
          ev.serial           = frame_shift[39:24];
          ev.count            = frame_count;
          ev.delta            = frame_count - previous_count;
          previous_count_next = frame_count;
          byte_position_next  = 3'd0;
          frame_shift_next    = 40'd0;
        end else begin
          frame_shift_next   = {frame_shift[31:0], data_byte};
          byte_position_next = byte_position + 3'd1;
        end
      end
      sfc_pkg::PH_SYNC_A: begin
        if (!is_sync) begin
          ev_valid = 1'b1;
          ev.kind  = sfc_pkg::EV_LOST;
        end
      end
      sfc_pkg::PH_SYNC_B: begin
        if (!is_sync) begin
          ev_valid = 1'b1;
          ev.kind  = sfc_pkg::EV_LOST;
        end else begin
          byte_position_next = 3'd0;
        end
      end
      default: begin
        ev_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= sfc_pkg::PH_HUNT;
      previous_byte  <= 8'd0;
      byte_position  <= 3'd0;
      frame_shift    <= 40'd0;
      previous_count <= 32'd0;
    end else if (accept) begin
      phase          <= phase_next;
      previous_byte  <= data_byte;
      byte_position  <= byte_position_next;
      frame_shift    <= frame_shift_next;
      previous_count <= previous_count_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/sfc_out.sv
`default_nettype none
module sfc_out (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire sfc_pkg::event_t  push_ev,
  input  wire logic             out_stall,
  output logic                  out_valid,
  output sfc_pkg::event_t       out_ev,
  output logic                  full
);

  logic            skid_valid;
  sfc_pkg::event_t skid_ev;
  logic            take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (take || !out_valid) begin
        out_valid  <= skid_valid || push;
        skid_valid <= 1'b0;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take || !out_valid) begin
      out_ev <= skid_valid ? skid_ev : push_ev;
    end else if (push) begin
      skid_ev <= push_ev;
    end
  end

endmodule
`default_nettype wire

FILE: src/sync_frame_counter_deframer.sv
// Sync-word frame deframer with a running count difference.
// Bytes of the raw stream arrive on the input channel (in_valid, in_stall,
// data_byte), one request per byte. Events leave on the output channel
// (out_valid, out_stall, event_kind, serial_number, count_value, count_delta):
// sync gained, sync lost, or a decoded frame with its serial number, count
// and count minus the count of the previous frame.
// A byte is taken in every cycle in which in_valid is high and in_stall is
// low, so the sustained rate is one byte per clock. An event caused by a
// byte is registered when that byte is accepted; the byte decode is a single
// pass from the state registers to the output register.
// When the receiver stalls, one further event is held in a skid register;
// in_stall is raised only while that register is occupied.
// The sync byte value is set through the APB port at address 0 and resets
// to 0xff. Reset returns the block to the hunt with the previous byte and
// previous count at zero, and drops any event not yet delivered.
`default_nettype none
module sync_frame_counter_deframer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [7:0]                      data_byte,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [1:0]                      event_kind,
  output logic      [15:0]                     serial_number,
  output logic      [31:0]                     count_value,
  output logic signed [31:0]                   count_delta,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [sfc_pkg::PaddrWidth-1:0]  paddr,
  input  wire logic [31:0]                     pwdata,
  output logic      [31:0]                     prdata,
  output logic                                 pready
);

  logic            accept;
  logic            ev_valid;
  logic            full;
  logic [7:0]      sync_value;
  sfc_pkg::event_t ev;
  sfc_pkg::event_t out_ev;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  sfc_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .sync_value (sync_value)
  );

  sfc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .sync_value (sync_value),
    .ev_valid   (ev_valid),
    .ev         (ev)
  );

  sfc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && ev_valid),
    .push_ev   (ev),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_ev    (out_ev),
    .full      (full)
  );

  assign event_kind    = out_ev.kind;
  assign serial_number = out_ev.serial;
  assign count_value   = out_ev.count;
  assign count_delta   = $signed(out_ev.delta);

endmodule
`default_nettype wire

FILE: verif/sfc_event_checker.sv
module sfc_event_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [7:0]                     data_byte,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [1:0]                     event_kind,
  input  logic [15:0]                    serial_number,
  input  logic [31:0]                    count_value,
  input  logic signed [31:0]             count_delta,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [sfc_pkg::PaddrWidth-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output int                             error_count,
  output int                             events_pending
);

  sfc_pkg::phase_t phase;
  logic [7:0]      sync_byte;
  logic [7:0]      prev_byte;
  logic [2:0]      byte_pos;
  logic [39:0]     frame_bits;
  logic [31:0]     prev_count;
  logic [47:0]     full_frame;
  sfc_pkg::event_t expected_events[$];
  sfc_pkg::event_t head;

  initial begin
    error_count = 0;
    events_pending = 0;
  end

  task automatic queue_event(input sfc_pkg::event_kind_t kind, input logic [15:0] ser,
                             input logic [31:0] cnt, input logic [31:0] dlt);
    sfc_pkg::event_t e;
    e.kind = kind;
    e.serial = ser;
    e.count = cnt;
    e.delta = dlt;
    expected_events.push_back(e);
  endtask

  task automatic decode_byte(input logic [7:0] b);
    case (phase)
      sfc_pkg::PH_HUNT: begin
        if (prev_byte == sync_byte && b == sync_byte) begin
          phase = sfc_pkg::PH_COLLECT;
          byte_pos = '0;
          queue_event(sfc_pkg::EV_GAINED, '0, '0, '0);
        end
      end
      sfc_pkg::PH_COLLECT: begin
        if (byte_pos >= sfc_pkg::LastBytePos) begin
          full_frame = {frame_bits, b};
          queue_event(sfc_pkg::EV_FRAME, full_frame[47:32], full_frame[31:0],
                      full_frame[31:0] - prev_count);
          prev_count = full_frame[31:0];
          byte_pos = '0;
          frame_bits = '0;
          phase = sfc_pkg::PH_SYNC_A;
        end else begin
          frame_bits = {frame_bits[31:0], b};
          byte_pos = byte_pos + 3'd1;
        end
      end
      sfc_pkg::PH_SYNC_A: begin
        if (b != sync_byte) begin
          phase = sfc_pkg::PH_HUNT;
          queue_event(sfc_pkg::EV_LOST, '0, '0, '0);
        end else begin
          phase = sfc_pkg::PH_SYNC_B;
        end
      end
      default: begin
        if (b != sync_byte) begin
          phase = sfc_pkg::PH_HUNT;
          queue_event(sfc_pkg::EV_LOST, '0, '0, '0);
        end else begin
          phase = sfc_pkg::PH_COLLECT;
          byte_pos = '0;
        end
      end
    endcase
    prev_byte = b;
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase = sfc_pkg::PH_HUNT;
      sync_byte = sfc_pkg::SyncValueReset;
      prev_byte = '0;
      byte_pos = '0;
      frame_bits = '0;
      prev_count = '0;
      expected_events.delete();
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr[sfc_pkg::PaddrWidth-1:2] == sfc_pkg::RegSyncValue) begin
        sync_byte = pwdata[7:0];
      end
      if (in_valid && !in_stall) begin
        decode_byte(data_byte);
      end
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event, expected none, actual %h %h %h %h",
                   $time, event_kind, serial_number, count_value, count_delta);
          error_count++;
        end else begin
          head = expected_events.pop_front();
          check_field("event_kind", 32'(head.kind), 32'(event_kind));
          check_field("serial_number", 32'(head.serial), 32'(serial_number));
          check_field("count_value", head.count, count_value);
          check_field("count_delta", head.delta, count_delta);
        end
      end
    end
    events_pending = expected_events.size();
  end

endmodule

FILE: verif/tb_top.sv
module tb_top;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;
  localparam int LatencyCycles = 4;
  localparam logic [sfc_pkg::PaddrWidth-1:0] AddrSyncValue = {sfc_pkg::RegSyncValue, 2'b00};
  localparam logic [sfc_pkg::PaddrWidth-1:0] AddrSpare = AddrSyncValue + 3'd4;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [7:0]                     data_byte = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [1:0]                     event_kind;
  logic [15:0]                    serial_number;
  logic [31:0]                    count_value;
  logic signed [31:0]             count_delta;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [sfc_pkg::PaddrWidth-1:0] paddr = '0;
  logic [31:0]                    pwdata = '0;
  logic [31:0]                    prdata;
  logic                           pready;

  int         error_count;
  int         events_pending;
  int         cycles = 0;
  int         bytes_sent = 0;
  bit         in_fire = 1'b0;
  bit         out_fire = 1'b0;
  bit         no_gaps = 1'b0;
  bit         hold_req = 1'b0;
  logic [7:0] sync_now = sfc_pkg::SyncValueReset;
  logic [31:0] last_cnt = '0;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  sync_frame_counter_deframer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall), .event_kind(event_kind),
    .serial_number(serial_number), .count_value(count_value), .count_delta(count_delta),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sfc_event_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall), .event_kind(event_kind),
    .serial_number(serial_number), .count_value(count_value), .count_delta(count_delta),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .error_count(error_count), .events_pending(events_pending)
  );

  always @(posedge clk) begin
    in_fire <= !rst && in_valid && !in_stall;
    out_fire <= !rst && out_valid && !out_stall;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    do @(negedge clk); while (!in_fire);
    bytes_sent++;
  endtask

  task automatic send_sync();
    send_byte(sync_now);
    send_byte(sync_now);
  endtask

  task automatic send_frame(input logic [15:0] ser, input logic [31:0] cnt);
    send_byte(ser[15:8]);
    send_byte(ser[7:0]);
    send_byte(cnt[31:24]);
    send_byte(cnt[23:16]);
    send_byte(cnt[15:8]);
    send_byte(cnt[7:0]);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (events_pending != 0);
    repeat (LatencyCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sfc_pkg::PaddrWidth-1:0] addr,
                           input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_sync(input logic [7:0] v);
    settle();
    write_reg(AddrSyncValue, ($urandom & 32'hffff_ff00) | {24'd0, v});
    sync_now = v;
  endtask

  // Mostly well-formed frames with random content, mixed with noise bytes,
  // broken sync words and frames cut short.
  task automatic random_traffic(input int target);
    int start;
    int pick;
    logic [31:0] cnt;
    logic [7:0] flip;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        send_sync();
        cnt = (pick < 35) ? $urandom : last_cnt + $urandom_range(0, 16);
        last_cnt = cnt;
        send_frame(16'($urandom), cnt);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (pick < 93) begin
        flip = 8'($urandom_range(1, 255));
        if ($urandom_range(0, 1) == 1) send_byte(sync_now);
        send_byte(sync_now ^ flip);
      end else begin
        send_sync();
        repeat ($urandom_range(0, 5)) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    int n;
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
      end
      n = no_gaps ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_fire && !hold_req);
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // The first sync byte after reset is compared against a zero previous byte.
    send_byte(8'hff);
    send_byte(8'hff);
    send_frame(16'h0000, 32'h0000_0000);
    send_sync();
    send_frame(16'hffff, 32'hffff_ffff);
    send_sync();
    send_frame(16'h8001, 32'h7fff_fffe);
    send_byte(sync_now);
    send_byte(8'h00);

    // A write beyond the register list must leave the sync byte alone.
    settle();
    write_reg(AddrSpare, 32'h0000_0000);
    send_sync();
    send_frame(16'h5aa5, 32'h8000_0000);
    set_sync(8'h00);
    send_byte(8'h00);
    random_traffic(300);

    set_sync(8'ha5);
    no_gaps = 1'b1;
    random_traffic(150);
    no_gaps = 1'b0;
    random_traffic(150);

    hold_req = 1'b1;
    no_gaps = 1'b1;
    random_traffic(80);
    no_gaps = 1'b0;
    settle();
    random_traffic(150);

    set_sync(8'($urandom_range(0, 255)));
    random_traffic(250);
    set_sync(8'hff);
    random_traffic(300);
    set_sync(8'($urandom_range(0, 255)));
    random_traffic(300);

    settle();
    if (error_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
